// File: hdl/sobel_edge_magnitude_rgb_core_macros.svh
// Assertion macros shared by the edge magnitude core.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_CORE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define SEM_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define SEM_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define SEM_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define SEM_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

// File: hdl/sem_pkg.sv
// Types and constants of the edge magnitude core.
package sem_pkg;

    localparam int CHAN_W     = 8;
    localparam int LW_W       = 12;
    localparam int FH_W       = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [LW_W-1:0] LINE_WIDTH_RESET   = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 16'd480;

    localparam logic [CHAN_W-1:0] EDGE_MAX = 8'd255;
    // sqrt of anything above this exceeds 255.5, so it saturates to 255
    localparam logic [20:0] MAG_SAT_LIMIT = 21'd65280;

    typedef logic signed [2:0] coef_t;
    typedef logic [3*CHAN_W-1:0] rgb_t;

    localparam coef_t KERN_X [3][3] = '{'{-3'sd1, 3'sd0, 3'sd1},
                                        '{-3'sd2, 3'sd0, 3'sd2},
                                        '{-3'sd1, 3'sd0, 3'sd1}};
    localparam coef_t KERN_Y [3][3] = '{'{-3'sd1, -3'sd2, -3'sd1},
                                        '{ 3'sd0,  3'sd0,  3'sd0},
                                        '{ 3'sd1,  3'sd2,  3'sd1}};

endpackage

// File: hdl/sem_if.sv
// Stream channels of the edge magnitude core.
interface sem_pixel_if import sem_pkg::*;;
    logic              valid;
    logic              ready;
    logic              action;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source (output valid, action, red, green, blue, input ready);
    modport sink   (input valid, action, red, green, blue, output ready);
endinterface

interface sem_result_if import sem_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] edge_red;
    logic [CHAN_W-1:0] edge_green;
    logic [CHAN_W-1:0] edge_blue;
    logic              frame_end;

    modport source (output valid, edge_red, edge_green, edge_blue, frame_end, input ready);
    modport sink   (input valid, edge_red, edge_green, edge_blue, frame_end, output ready);
endinterface

// File: hdl/sobel_edge_magnitude_rgb_core.sv
// Sobel edge magnitude core: RGB pixels in raster order, two line stores in
// block RAM and a 3x3 window; per channel it outputs round(sqrt(Gx^2+Gy^2))
// saturated to 255, with pixels outside the frame taken as zero. The result
// for a pixel leaves with the item that arrives line_width+1 items later;
// after the frame's last pixel send flush items to drain it. An item that
// yields no result passes ST_IDLE and ST_READ; one that yields a result also
// passes ST_SUM, ST_SQUARE, ST_ROOT (the one-bit-per-cycle square root unit)
// and ST_DONE, where it waits for the output register to drain. Register
// writes restart the frame; no clearing pass runs after reset.
`include "sobel_edge_magnitude_rgb_core_macros.svh"

module sobel_edge_magnitude_rgb_core
    import sem_pkg::*;
#(
    parameter int MAX_LINE = 2048
) (
    input  logic                  clk,
    input  logic                  rst_n,
    sem_pixel_if.sink             pixels,
    sem_result_if.source          results,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_LINE);
    localparam int WW = $clog2(MAX_LINE + 1);
    localparam int EW = (WW > LW_W) ? WW : LW_W;
    localparam int RW = FH_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_SQUARE,
        ST_ROOT,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [LW_W-1:0]    line_width_reg;
    logic [FH_W-1:0]    frame_height_reg;
    logic [CW-1:0]      in_column_reg;
    logic [RW-1:0]      in_row_reg;
    logic [CW-1:0]      out_column_reg;
    logic [FH_W-1:0]    out_row_reg;
    rgb_t               win_reg [3][3];
    rgb_t               pix_reg;
    logic [CW-1:0]      col_reg;
    rgb_t               near_q_reg;
    rgb_t               far_q_reg;
    logic [9:0]         ax_reg [3];
    logic [9:0]         ay_reg [3];
    logic [20:0]        g_reg [3];
    logic [CHAN_W-1:0]  n_reg [3];
    logic [2:0]         bit_reg;
    logic               last_reg;
    logic               out_valid_reg;
    logic [CHAN_W-1:0]  out_edge_reg [3];
    logic               out_end_reg;

    rgb_t               near_mem [MAX_LINE];
    rgb_t               far_mem [MAX_LINE];

    logic [EW-1:0]      eff_w;
    logic [FH_W-1:0]    eff_h;
    logic               in_col_wrap;
    logic               emit;
    logic               out_col_last;
    logic               out_row_last;
    logic               accept;
    logic               out_free;
    logic [9:0]         ax_comb [3];
    logic [9:0]         ay_comb [3];
    logic [CHAN_W-1:0]  n_next [3];
    logic [CHAN_W-1:0]  edge_next [3];

    always_comb
    begin
        if (line_width_reg == '0)
            eff_w = EW'(1);
        else if (EW'(line_width_reg) > EW'(MAX_LINE))
            eff_w = EW'(MAX_LINE);
        else
            eff_w = EW'(line_width_reg);
        eff_h = (frame_height_reg == '0) ? FH_W'(1) : frame_height_reg;
    end

    assign in_col_wrap  = (EW'(in_column_reg) + EW'(1)) >= eff_w;
    assign emit         = (in_row_reg >= RW'(2)) ||
                          ((in_row_reg == RW'(1)) && (in_column_reg != '0));
    assign out_col_last = (EW'(out_column_reg) + EW'(1)) >= eff_w;
    assign out_row_last = (RW'(out_row_reg) + RW'(1)) >= RW'(eff_h);
    assign accept       = pixels.valid && pixels.ready;
    assign out_free     = !out_valid_reg || results.ready;

    assign pixels.ready       = (state_reg == ST_IDLE);
    assign results.valid      = out_valid_reg;
    assign results.edge_red   = out_edge_reg[0];
    assign results.edge_green = out_edge_reg[1];
    assign results.edge_blue  = out_edge_reg[2];
    assign results.frame_end  = out_end_reg;

    // Sobel sums per channel, neighbors outside the frame masked off
    always_comb
    begin
        logic signed [11:0] gx;
        logic signed [11:0] gy;
        logic signed [11:0] v;
        logic               use_px;
        for (int ch = 0; ch < 3; ch++)
        begin
            gx = '0;
            gy = '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    use_px = !((r == 0) && (out_row_reg == '0)) &&
                             !((r == 2) && out_row_last) &&
                             !((c == 0) && (out_column_reg == '0)) &&
                             !((c == 2) && out_col_last);
                    v = use_px ? $signed({4'd0, win_reg[r][c][16-8*ch +: 8]}) : 12'sd0;
                    gx = gx + 12'(KERN_X[r][c] * v);
                    gy = gy + 12'(KERN_Y[r][c] * v);
                end
            end
            ax_comb[ch] = gx[11] ? 10'(-gx) : 10'(gx);
            ay_comb[ch] = gy[11] ? 10'(-gy) : 10'(gy);
        end
    end

    // One root bit per cycle, then round to nearest and saturate
    always_comb
    begin
        logic [CHAN_W-1:0] t;
        logic [16:0]       nn;
        for (int ch = 0; ch < 3; ch++)
        begin
            t = n_reg[ch] | (8'd1 << bit_reg);
            n_next[ch] = ({5'd0, 16'(t * t)} <= g_reg[ch]) ? t : n_reg[ch];
            nn = 17'(n_reg[ch] * n_reg[ch]) + 17'(n_reg[ch]);
            if (g_reg[ch] > MAG_SAT_LIMIT)
                edge_next[ch] = EDGE_MAX;
            else if (g_reg[ch] > 21'(nn))
                edge_next[ch] = n_reg[ch] + 8'd1;
            else
                edge_next[ch] = n_reg[ch];
        end
    end

    // Line stores: read on transfer, written back in the next cycle (ST_READ)
    always_ff @(posedge clk)
    begin
        if (accept)
            near_q_reg <= near_mem[in_column_reg];
        if (state_reg == ST_READ)
            near_mem[col_reg] <= pix_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            far_q_reg <= far_mem[in_column_reg];
        if (state_reg == ST_READ)
            far_mem[col_reg] <= near_q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            line_width_reg   <= LINE_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            in_column_reg    <= '0;
            in_row_reg       <= '0;
            out_column_reg   <= '0;
            out_row_reg      <= '0;
            out_valid_reg    <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
            end
        end
        else
        begin
            // in ST_DONE the register is always refilled when the transfer goes out
            if (results.ready && (state_reg != ST_DONE))
                out_valid_reg <= 1'b0;

            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    CFG_LINE_WIDTH:   line_width_reg   <= cfg_data[LW_W-1:0];
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                    default: ;
                endcase
                in_column_reg  <= '0;
                in_row_reg     <= '0;
                out_column_reg <= '0;
                out_row_reg    <= '0;
                for (int r = 0; r < 3; r++)
                begin
                    for (int c = 0; c < 3; c++)
                        win_reg[r][c] <= '0;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        col_reg <= in_column_reg;
                        if ((in_row_reg < RW'(eff_h)) && !pixels.action)
                            pix_reg <= {pixels.red, pixels.green, pixels.blue};
                        else
                            pix_reg <= '0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        win_reg[r][0] <= win_reg[r][1];
                        win_reg[r][1] <= win_reg[r][2];
                    end
                    win_reg[0][2] <= far_q_reg;
                    win_reg[1][2] <= near_q_reg;
                    win_reg[2][2] <= pix_reg;
                    if (in_col_wrap)
                    begin
                        in_column_reg <= '0;
                        in_row_reg    <= in_row_reg + RW'(1);
                    end
                    else
                    begin
                        in_column_reg <= in_column_reg + CW'(1);
                    end
                    state_reg <= emit ? ST_SUM : ST_IDLE;
                end
                ST_SUM:
                begin
                    ax_reg   <= ax_comb;
                    ay_reg   <= ay_comb;
                    last_reg <= out_row_last && out_col_last;
                    if (out_row_last && out_col_last)
                    begin
                        // frame done: restart positions and window
                        in_column_reg  <= '0;
                        in_row_reg     <= '0;
                        out_column_reg <= '0;
                        out_row_reg    <= '0;
                        for (int r = 0; r < 3; r++)
                        begin
                            for (int c = 0; c < 3; c++)
                                win_reg[r][c] <= '0;
                        end
                    end
                    else if (out_col_last)
                    begin
                        out_column_reg <= '0;
                        out_row_reg    <= out_row_reg + FH_W'(1);
                    end
                    else
                    begin
                        out_column_reg <= out_column_reg + CW'(1);
                    end
                    state_reg <= ST_SQUARE;
                end
                ST_SQUARE:
                begin
                    for (int ch = 0; ch < 3; ch++)
                    begin
                        g_reg[ch] <= 21'(ax_reg[ch] * ax_reg[ch]) +
                                     21'(ay_reg[ch] * ay_reg[ch]);
                        n_reg[ch] <= '0;
                    end
                    bit_reg   <= 3'd7;
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    n_reg   <= n_next;
                    bit_reg <= bit_reg - 3'd1;
                    if (bit_reg == 3'd0)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_edge_reg  <= edge_next;
                        out_end_reg   <= last_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `SEM_ASSERT_NXT(a_accept_reads, clk, rst_n, accept, state_reg == ST_READ)
    `SEM_ASSERT_NXT(a_frame_restart, clk, rst_n,
        (state_reg == ST_SUM) && out_row_last && out_col_last,
        (in_column_reg == '0) && (in_row_reg == '0) && (out_row_reg == '0))
    `SEM_ASSERT_IMP(a_out_row_range, clk, rst_n, state_reg == ST_SUM,
        RW'(out_row_reg) < RW'(eff_h))

endmodule

// File: verif/sem_tb_if.sv
`timescale 1ns / 100ps
// Note: the channel interfaces come from the RTL (sem_if.sv); this file only holds the scoreboard types.
package sem_tb_pkg;
    import sem_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic              fe;
    } edge_res_t;

    // Shadow of the core: window, line stores and positions; predicts each result.
    class edge_scoreboard;
        int unsigned lw, fh;
        rgb_t near_row [2048];
        rgb_t far_row [2048];
        rgb_t win [3][3];
        int unsigned in_col, in_row, out_col, out_row;
        edge_res_t pending [$];
        int errors;
        int matched;

        function new();
            lw = LINE_WIDTH_RESET;
            fh = FRAME_HEIGHT_RESET;
            errors = 0;
            matched = 0;
            restart();
        endfunction

        function void restart();
            foreach (win[r, c]) win[r][c] = '0;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_LINE_WIDTH) lw = data[LW_W-1:0];
            else if (idx == CFG_FRAME_HEIGHT) fh = data[FH_W-1:0];
            restart();
        endfunction

        function int unsigned eff_w();
            if (lw == 0) return 1;
            return (lw > 2048) ? 2048 : lw;
        endfunction

        function int unsigned eff_h();
            return (fh == 0) ? 1 : fh;
        endfunction

        static function logic [CHAN_W-1:0] round_root(int unsigned g);
            int unsigned n;
            int unsigned t;
            n = 0;
            if (g > MAG_SAT_LIMIT) return EDGE_MAX;
            for (int b = 7; b >= 0; b--) begin
                t = n | (1 << b);
                if (t * t <= g) n = t;
            end
            if (g > n * n + n) n++;
            return (n > 255) ? EDGE_MAX : n[7:0];
        endfunction

        function void note_pixel(logic act, rgb_t px);
            int unsigned w, h, col;
            rgb_t v;
            bit fire;
            edge_res_t res;
            int gx, gy, p, sh;
            logic [CHAN_W-1:0] m [3];
            w = eff_w();
            h = eff_h();
            col = in_col % 2048;
            v = (in_row < h && !act) ? px : '0;
            for (int r = 0; r < 3; r++)
            begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = far_row[col];
            win[1][2] = near_row[col];
            win[2][2] = v;
            far_row[col] = near_row[col];
            near_row[col] = v;
            fire = in_row >= 2 || (in_row == 1 && in_col >= 1);
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
            if (!fire) return;
            for (int ch = 0; ch < 3; ch++)
            begin
                sh = 16 - 8 * ch;
                gx = 0;
                gy = 0;
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                    begin
                        if (r == 0 && out_row == 0) continue;
                        if (r == 2 && out_row + 1 >= h) continue;
                        if (c == 0 && out_col == 0) continue;
                        if (c == 2 && out_col + 1 >= w) continue;
                        p = (win[r][c] >> sh) & 8'hFF;
                        gx += KERN_X[r][c] * p;
                        gy += KERN_Y[r][c] * p;
                    end
                m[ch] = round_root(gx * gx + gy * gy);
            end
            res.r = m[0];
            res.g = m[1];
            res.b = m[2];
            if (out_row + 1 >= h && out_col + 1 >= w)
            begin
                res.fe = 1'b1;
                restart();
            end
            else
            begin
                res.fe = 1'b0;
                out_col++;
                if (out_col >= w)
                begin
                    out_col = 0;
                    out_row++;
                end
            end
            pending.push_back(res);
        endfunction

        function void check_result(edge_res_t got);
            edge_res_t exp;
            if (pending.size() == 0)
            begin
                $error("unexpected result r=%0d g=%0d b=%0d", got.r, got.g, got.b);
                errors++;
                return;
            end
            exp = pending.pop_front();
            matched++;
            if (got.r !== exp.r)
            begin
                $error("edge_red exp %0d got %0d", exp.r, got.r);
                errors++;
            end
            if (got.g !== exp.g)
            begin
                $error("edge_green exp %0d got %0d", exp.g, got.g);
                errors++;
            end
            if (got.b !== exp.b)
            begin
                $error("edge_blue exp %0d got %0d", exp.b, got.b);
                errors++;
            end
            if (got.fe !== exp.fe)
            begin
                $error("frame_end exp %0d got %0d", exp.fe, got.fe);
                errors++;
            end
        endfunction
    endclass
endpackage

// File: verif/tb_sobel_edge_magnitude_rgb_core.sv
`timescale 1ns / 100ps
// Top-level testbench of the Sobel edge magnitude core.
module tb_sobel_edge_magnitude_rgb_core;
    import sem_pkg::*;
    import sem_tb_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int unsigned cycles;
    int sent;
    int stall_mode;
    bit hold_off;
    bit gaps_on;
    edge_scoreboard sb;

    sem_pixel_if pixels ();
    sem_result_if results ();

    sobel_edge_magnitude_rgb_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixels       (pixels.sink),
        .results      (results.source),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 1500000)
            begin
                $display("tb_sobel_edge_magnitude_rgb_core: done, errors");
                $finish;
            end
        end
    end

    // Receiver: stall on a shifting pattern, or hold off fully while hold_off is set.
    initial
    begin
        results.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && results.valid && results.ready)
                sb.check_result({results.edge_red, results.edge_green,
                                 results.edge_blue, results.frame_end});
            if (hold_off) results.ready <= 1'b0;
            else case (stall_mode)
                0: results.ready <= 1'b1;
                1: results.ready <= ($urandom_range(0, 3) != 0);
                2: results.ready <= cycles[2];
                default: results.ready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    initial
    begin
        forever
        begin
            #(50000 + $urandom_range(0, 50000));
            stall_mode = $urandom_range(0, 3);
        end
    end

    task automatic send_pixel(logic act, rgb_t px);
        int gap;
        gap = gaps_on ? (($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0) : 0;
        repeat (gap)
        begin
            pixels.valid <= 1'b0;
            @(posedge clk);
        end
        pixels.valid <= 1'b1;
        pixels.action <= act;
        {pixels.red, pixels.green, pixels.blue} <= px;
        do @(posedge clk); while (!pixels.ready);
        sb.note_pixel(act, px);
        sent++;
    endtask

    task automatic go_idle();
        pixels.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        go_idle();
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // One frame of pixels, optional flush holes and noise, then the drain.
    task automatic run_frame(int unsigned w, int unsigned h, int kind);
        rgb_t px;
        for (int i = 0; i < w * h; i++)
        begin
            case (kind)
                0: px = 24'($urandom);
                1: px = ($urandom_range(0, 1)) ? 24'hFFFFFF : 24'h000000;
                default: px = {8'($urandom_range(0, 15)), 8'($urandom), 8'($urandom_range(240, 255))};
            endcase
            send_pixel(($urandom_range(0, 19) == 0), px);
        end
        for (int i = 0; i < w + 1; i++)
            send_pixel($urandom_range(0, 3) != 0, 24'($urandom));
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
    endtask

    initial
    begin
        int unsigned w, h;
        sb = new();
        sent = 0;
        stall_mode = 0;
        hold_off = 1'b0;
        gaps_on = 1'b0;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = CFG_LINE_WIDTH;
        cfg_data = '0;
        pixels.valid = 1'b0;
        pixels.action = 1'b0;
        pixels.red = '0;
        pixels.green = '0;
        pixels.blue = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 3x3 frame with extreme pixels, then degenerate sizes.
        set_size(3, 3);
        send_pixel(1'b0, 24'hFFFFFF);
        send_pixel(1'b0, 24'h000000);
        send_pixel(1'b0, 24'hFF00FF);
        send_pixel(1'b1, 24'hFFFFFF);
        send_pixel(1'b0, 24'h00FF00);
        send_pixel(1'b0, 24'hFFFFFF);
        send_pixel(1'b0, 24'h000000);
        send_pixel(1'b0, 24'hFFFFFF);
        send_pixel(1'b0, 24'h0F0F0F);
        for (int i = 0; i < 4; i++) send_pixel(1'b0, 24'hAAAAAA);
        set_size(0, 0);
        send_pixel(1'b0, 24'hFFFFFF);
        send_pixel(1'b1, 24'h0);
        set_size(1, 3);
        run_frame(1, 3, 1);

        // Random frames, small sizes mostly.
        gaps_on = 1'b1;
        while (sent < 1380)
        begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
            h = $urandom_range(0, 6);
            set_size(w, h);
            run_frame((w == 0) ? 1 : w, (h == 0) ? 1 : h, $urandom_range(0, 2));
            if ($urandom_range(0, 3) == 0) go_idle();
        end

        // Long hold-off on the receiver while items keep coming.
        set_size(4, 4);
        fork
        begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk);
            hold_off = 1'b0;
        end
        run_frame(4, 4, 0);
        join

        set_size(640, 480);

        go_idle();
        repeat (40) @(posedge clk);
        $display("Sent %0d items over frames 1x1 to 40 wide; %0d results checked.",
                 sent, sb.matched);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_sobel_edge_magnitude_rgb_core: done, clean");
        else
            $display("tb_sobel_edge_magnitude_rgb_core: done, errors");
        $finish;
    end
endmodule
